/* rtl/core/lsfrk4_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfrk4_pkg
// Shared types, widths and helpers for the linear state-feedback RK4 core.
// ----------------------------------------------------------------------------
package lsfrk4_pkg;

  localparam int STATE_W    = 32;
  localparam int COEF_W     = 21;
  localparam int COEF_SLOT  = 21;
  localparam int DT_W       = 20;
  localparam int IO_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int Q_SHIFT    = 15;

  // multiplier operands: state or held drive times coefficient or dt
  localparam int MA_W  = (STATE_W > IO_W) ? STATE_W : IO_W;
  localparam int MB_W  = DT_W + 1;
  localparam int P_W   = MA_W + MB_W;
  localparam int ACC_W = MA_W + 24;

  // divide-by-6 = shift by one, then divide by 3 on a biased, nonnegative value
  localparam int DV_W      = ACC_W - Q_SHIFT - 1;
  localparam int DIV_DIGIT = 8;
  localparam int DIV_STEPS = (DV_W + DIV_DIGIT) / DIV_DIGIT;
  localparam int DIVP_W    = DIV_STEPS * DIV_DIGIT;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DT_W-1:0]         DT_RESET   = DT_W'(328);
  localparam logic [DIVP_W-1:0]       DIV_BIAS   = DIVP_W'(3) << (DV_W - 1);
  localparam logic signed [ACC_W-1:0] DIV_OFFSET = ACC_W'(1) << (DV_W - 1);

  localparam logic [CFG_IDX_W-1:0] REG_A_ROW0  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_ROW1  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_A_ROW2  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_B_COL   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_C_ROW   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_K_GAIN  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_DT      = CFG_IDX_W'(6);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SLOPE = 6'b000010,
    ST_POINT = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    DST_K,
    DST_Y,
    DST_U,
    DST_PT
  } dest_e;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       last;
    dest_e      dest;
    logic [1:0] idx;
    logic [1:0] stage;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0]           rem;
    logic [DIV_DIGIT-1:0] q;
  } div_step_t;

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-STATE_W:0] top;
    top = v[ACC_W-1:STATE_W-1];
    if ((&top) || !(|top)) return v[STATE_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(STATE_W-1){1'b0}}};
    else return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  function automatic logic signed [IO_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-IO_W:0] top;
    top = v[ACC_W-1:IO_W-1];
    if ((&top) || !(|top)) return v[IO_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(IO_W-1){1'b0}}};
    else return {1'b0, {(IO_W-1){1'b1}}};
  endfunction

  // one radix-256 digit of unsigned division by 3, remainder stays below 3
  function automatic div_step_t div3_digit(input logic [1:0] rem_in,
                                           input logic [DIV_DIGIT-1:0] bits);
    logic [2:0] r;
    logic [1:0] rc;
    div_step_t  res;
    rc  = rem_in;
    res = '0;
    for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
      r = {rc, bits[i]};
      if (r >= 3'd3) begin
        res.q[i] = 1'b1;
        rc       = 2'(r - 3'd3);
      end else begin
        res.q[i] = 1'b0;
        rc       = r[1:0];
      end
    end
    res.rem = rc;
    return res;
  endfunction

endpackage

/* rtl/core/lsfrk4_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfrk4 channel interfaces
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface lsfrk4_in_if import lsfrk4_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic signed [IO_W-1:0] load_state_zero;
  logic signed [IO_W-1:0] load_state_one;
  logic signed [IO_W-1:0] load_state_two;

  modport source (
    output valid, func, load_state_zero, load_state_one, load_state_two,
    input  ready
  );
  modport sink (
    input  valid, func, load_state_zero, load_state_one, load_state_two,
    output ready
  );
endinterface

interface lsfrk4_out_if import lsfrk4_pkg::*; ;
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] measured_output;
  logic signed [IO_W-1:0] drive_value;
  logic signed [IO_W-1:0] state_out_zero;
  logic signed [IO_W-1:0] state_out_one;
  logic signed [IO_W-1:0] state_out_two;

  modport source (
    output valid, measured_output, drive_value, state_out_zero, state_out_one,
           state_out_two,
    input  ready
  );
  modport sink (
    input  valid, measured_output, drive_value, state_out_zero, state_out_one,
           state_out_two,
    output ready
  );
endinterface

/* rtl/core/linear_state_feedback_rk4_step_core.sv */
`timescale 1ns / 1ps
// Commands: a load beat writes the plant state when accepted. A step beat runs
//   the slope, point, divide and output phases before its result beat, paced
//   by the single shared multiply-accumulate (one product per cycle) and the
//   digit-serial divide by 6. A beat is taken only in idle, once a step is done.
// Reset: asynchronous, clears plant state, held drive and registers (dt = 328).
// ----------------------------------------------------------------------------
// linear_state_feedback_rk4_step_core
// Three-state linear plant with state feedback, one RK4 step per step command.
// ----------------------------------------------------------------------------
module linear_state_feedback_rk4_step_core import lsfrk4_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lsfrk4_in_if.sink             in_i,
  lsfrk4_out_if.source          out_o
);

  // configuration
  logic signed [COEF_W-1:0] a_q [3][3];
  logic signed [COEF_W-1:0] b_q [3];
  logic signed [COEF_W-1:0] c_q [3];
  logic signed [COEF_W-1:0] kg_q [3];
  logic [DT_W-1:0]          dt_q;

  // control
  state_e               state_q;
  logic [1:0]           stage_q, row_q, term_q, elem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  mac_ctl_t             ctl_d, ctl_q;
  logic                 ov_q;

  // plant and datapath
  logic signed [STATE_W-1:0] x_q [3];
  logic signed [STATE_W-1:0] xt_q [3];
  logic signed [STATE_W-1:0] k_q [3];
  logic signed [STATE_W-1:0] src_x [3];
  logic signed [ACC_W-1:0]   s_q [3];
  logic signed [IO_W-1:0]    u_q, y_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [P_W-1:0]     prod, prod_q;
  logic [1:0]                col;

  logic signed [ACC_W-1:0]   prod_x, mac_term, half_term, mac_sum, wterm;
  logic signed [STATE_W-1:0] pt_next;

  logic [DIVP_W-1:0]         dvd_q, quo_q, quo_d;
  logic [1:0]                rem_q;
  div_step_t                 dstep;
  logic signed [DV_W-1:0]    div_v;
  logic signed [STATE_W-1:0] div_x;
  logic                      div_load, div_iter, div_last;

  logic signed [IO_W-1:0]    o_y_q, o_u_q;
  logic signed [IO_W-1:0]    o_x_q [3];
  logic                      in_acc, out_load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_DONE) && !ctl_q.vld && (!ov_q || out_o.ready);

  // --------------------------------------------------------------------------
  // issue: operand select for the shared multiplier
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      src_x[i] = (stage_q == 2'd0) ? x_q[i] : xt_q[i];
    end
  end

  assign col = term_q - 2'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ctl_d = '0;
    unique case (state_q)
      ST_SLOPE: begin
        // term 0 is B*u, terms 1..3 are A[row][col]*x[col]
        if (term_q == 2'd0) begin
          mul_a = MA_W'(u_q);
          mul_b = MB_W'(b_q[row_q]);
        end else begin
          mul_a = MA_W'(src_x[col]);
          mul_b = MB_W'(a_q[row_q][col]);
        end
        ctl_d.vld   = 1'b1;
        ctl_d.first = (term_q == 2'd0);
        ctl_d.last  = (term_q == 2'd3);
        ctl_d.dest  = DST_K;
        ctl_d.idx   = row_q;
        ctl_d.stage = stage_q;
      end
      ST_POINT: begin
        mul_a       = MA_W'(k_q[elem_q]);
        mul_b       = $signed({1'b0, dt_q});
        ctl_d.vld   = 1'b1;
        ctl_d.dest  = DST_PT;
        ctl_d.idx   = elem_q;
        ctl_d.stage = stage_q;
      end
      ST_OUT: begin
        mul_a       = MA_W'(x_q[row_q]);
        mul_b       = term_q[0] ? MB_W'(kg_q[row_q]) : MB_W'(c_q[row_q]);
        ctl_d.vld   = 1'b1;
        ctl_d.first = (row_q == 2'd0);
        ctl_d.last  = (row_q == 2'd2);
        ctl_d.dest  = term_q[0] ? DST_U : DST_Y;
        ctl_d.idx   = row_q;
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // writeback arithmetic on the registered product
  // --------------------------------------------------------------------------
  assign prod_x    = ACC_W'(prod_q);
  assign mac_term  = prod_x >>> Q_SHIFT;
  assign half_term = prod_x >>> (Q_SHIFT + 1);
  assign mac_sum   = (ctl_q.first ? '0 : acc_q) + mac_term;
  // RK4 weights 1, 2, 2, 1 on the exact k*dt products
  assign wterm     = ((ctl_q.stage == 2'd1) || (ctl_q.stage == 2'd2)) ? (prod_x <<< 1) : prod_x;
  assign pt_next   = sat_state(ACC_W'(x_q[ctl_q.idx]) +
                               ((ctl_q.stage == 2'd2) ? mac_term : half_term));

  // --------------------------------------------------------------------------
  // divide by 6: floor(S / 2^16) biased positive, then 8 quotient bits a cycle
  // --------------------------------------------------------------------------
  assign div_load = (state_q == ST_DIV) && (dcnt_q == '0);
  assign div_iter = (state_q == ST_DIV) && (dcnt_q != '0);
  assign div_last = div_iter && (dcnt_q == DIV_CNT_W'(DIV_STEPS));
  assign div_v    = s_q[elem_q][ACC_W-1:Q_SHIFT+1];
  assign dstep    = div3_digit(rem_q, dvd_q[DIVP_W-1 -: DIV_DIGIT]);
  assign quo_d    = {quo_q[DIVP_W-DIV_DIGIT-1:0], dstep.q};
  assign div_x    = sat_state(ACC_W'(x_q[elem_q]) + $signed(ACC_W'(quo_d)) - DIV_OFFSET);

  // --------------------------------------------------------------------------
  // control, plant state, configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= '0;
      row_q   <= '0;
      term_q  <= '0;
      elem_q  <= '0;
      dcnt_q  <= '0;
      ctl_q   <= '0;
      ov_q    <= 1'b0;
      u_q     <= '0;
      dt_q    <= DT_RESET;
      for (int i = 0; i < 3; i++) begin
        x_q[i]  <= '0;
        b_q[i]  <= '0;
        c_q[i]  <= '0;
        kg_q[i] <= '0;
        for (int j = 0; j < 3; j++) begin
          a_q[i][j] <= '0;
        end
      end
    end else begin
      ctl_q <= ctl_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_A_ROW0: for (int j = 0; j < 3; j++) a_q[0][j] <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_A_ROW1: for (int j = 0; j < 3; j++) a_q[1][j] <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_A_ROW2: for (int j = 0; j < 3; j++) a_q[2][j] <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_B_COL:  for (int j = 0; j < 3; j++) b_q[j]    <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_C_ROW:  for (int j = 0; j < 3; j++) c_q[j]    <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_K_GAIN: for (int j = 0; j < 3; j++) kg_q[j]   <= cfg_data_i[COEF_SLOT*j +: COEF_W];
          REG_DT:     dt_q <= cfg_data_i[DT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end

      if (ctl_q.vld && ctl_q.last && (ctl_q.dest == DST_U)) begin
        u_q <= sat_out(-mac_sum);
      end

      if (div_last) begin
        x_q[elem_q] <= div_x;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.func == FUNC_LOAD) begin
              x_q[0] <= sat_state(ACC_W'(in_i.load_state_zero));
              x_q[1] <= sat_state(ACC_W'(in_i.load_state_one));
              x_q[2] <= sat_state(ACC_W'(in_i.load_state_two));
              u_q    <= '0;
            end else begin
              state_q <= ST_SLOPE;
              stage_q <= '0;
              row_q   <= '0;
              term_q  <= '0;
            end
          end
        end
        ST_SLOPE: begin
          term_q <= term_q + 2'd1;
          if (term_q == 2'd3) begin
            if (row_q == 2'd2) begin
              row_q   <= '0;
              elem_q  <= '0;
              state_q <= ST_POINT;
            end else begin
              row_q <= row_q + 2'd1;
            end
          end
        end
        ST_POINT: begin
          if (elem_q == 2'd2) begin
            elem_q <= '0;
            term_q <= '0;
            if (stage_q == 2'd3) begin
              dcnt_q  <= '0;
              state_q <= ST_DIV;
            end else begin
              stage_q <= stage_q + 2'd1;
              state_q <= ST_SLOPE;
            end
          end else begin
            elem_q <= elem_q + 2'd1;
          end
        end
        ST_DIV: begin
          if (div_last) begin
            dcnt_q <= '0;
            if (elem_q == 2'd2) begin
              elem_q  <= '0;
              row_q   <= '0;
              term_q  <= '0;
              state_q <= ST_OUT;
            end else begin
              elem_q <= elem_q + 2'd1;
            end
          end else begin
            dcnt_q <= dcnt_q + DIV_CNT_W'(1);
          end
        end
        ST_OUT: begin
          // term_q[0] selects C (y) then K (u)
          if (row_q == 2'd2) begin
            row_q <= '0;
            if (term_q[0]) begin
              state_q <= ST_DONE;
            end else begin
              term_q <= 2'd1;
            end
          end else begin
            row_q <= row_q + 2'd1;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod;

    if (ctl_q.vld && (ctl_q.dest != DST_PT)) begin
      acc_q <= mac_sum;
      if (ctl_q.last) begin
        unique case (ctl_q.dest)
          DST_K:   k_q[ctl_q.idx] <= sat_state(mac_sum);
          DST_Y:   y_q <= sat_out(mac_sum);
          default: ;
        endcase
      end
    end

    if (ctl_q.vld && (ctl_q.dest == DST_PT)) begin
      s_q[ctl_q.idx] <= ((ctl_q.stage == 2'd0) ? '0 : s_q[ctl_q.idx]) + wterm;
      if (ctl_q.stage != 2'd3) begin
        xt_q[ctl_q.idx] <= pt_next;
      end
    end

    if (div_load) begin
      dvd_q <= DIVP_W'(div_v) + DIV_BIAS;
      rem_q <= '0;
      quo_q <= '0;
    end else if (div_iter) begin
      dvd_q <= dvd_q << DIV_DIGIT;
      rem_q <= dstep.rem;
      quo_q <= quo_d;
    end

    if (out_load) begin
      o_y_q <= y_q;
      o_u_q <= u_q;
      for (int i = 0; i < 3; i++) begin
        o_x_q[i] <= sat_out(ACC_W'(x_q[i]));
      end
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.measured_output = o_y_q;
  assign out_o.drive_value     = o_u_q;
  assign out_o.state_out_zero  = o_x_q[0];
  assign out_o.state_out_one   = o_x_q[1];
  assign out_o.state_out_two   = o_x_q[2];

endmodule

/* test/tb_linear_state_feedback_rk4_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_state_feedback_rk4_step_core
// Self-checking bench for the RK4 plant core. It keeps its own fixed-point
// copy of the plant, predicts every result beat of a step command and
// compares it field by field. The run covers loads, steps, saturation, a zero
// time step and an unused register index. Random trajectories run under
// several coefficient sets. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_linear_state_feedback_rk4_step_core;
  import lsfrk4_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(7);
  localparam int DRAIN_CYCLES = 100;
  localparam int COEF_ONE     = 32768;
  localparam int COEF_MAX     = (1 << (COEF_W - 1)) - 1;
  localparam int COEF_MIN     = -(1 << (COEF_W - 1));
  localparam logic [DT_W-1:0] DT_MAX = '1;
  localparam logic signed [IO_W-1:0] Q16_MAX = {1'b0, {(IO_W - 1){1'b1}}};
  localparam logic signed [IO_W-1:0] Q16_MIN = {1'b1, {(IO_W - 1){1'b0}}};
  localparam logic signed [IO_W-1:0] Q16_ONE = IO_W'(65536);

  typedef struct packed {
    logic signed [IO_W-1:0] y_meas;
    logic signed [IO_W-1:0] u_drive;
    logic signed [IO_W-1:0] x0;
    logic signed [IO_W-1:0] x1;
    logic signed [IO_W-1:0] x2;
  } plant_out_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsfrk4_in_if  cmd_if ();
  lsfrk4_out_if res_if ();

  linear_state_feedback_rk4_step_core DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_if),
    .out_o      (res_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // plant copy
  longint                plant_x [3];
  longint                drive_hold;
  logic [CFG_DATA_W-1:0] coef_reg [6];
  logic [DT_W-1:0]       dt_reg;

  plant_out_t pending_outputs [$];
  int         mismatch_count = 0;
  int         burst_left     = 0;

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // floor(a * c / 2^15)
  function automatic longint qmul(input longint a, input longint c);
    return (a * c) >>> Q_SHIFT;
  endfunction

  function automatic longint coef_of(input int reg_no, input int j);
    logic signed [COEF_W-1:0] c;
    c = coef_reg[reg_no][COEF_SLOT*j +: COEF_W];
    return longint'(c);
  endfunction

  function automatic longint slope_row(input int row, input longint x0, input longint x1,
                                       input longint x2);
    longint acc;
    acc = qmul(drive_hold, coef_of(int'(REG_B_COL), row)) + qmul(x0, coef_of(row, 0))
        + qmul(x1, coef_of(row, 1)) + qmul(x2, coef_of(row, 2));
    return clamp(acc, STATE_W);
  endfunction

  function automatic longint dot_row(input int reg_no);
    return qmul(plant_x[0], coef_of(reg_no, 0)) + qmul(plant_x[1], coef_of(reg_no, 1))
         + qmul(plant_x[2], coef_of(reg_no, 2));
  endfunction

  function automatic void load_plant(input logic signed [IO_W-1:0] s0,
                                     input logic signed [IO_W-1:0] s1,
                                     input logic signed [IO_W-1:0] s2);
    plant_x[0] = clamp(longint'(s0), STATE_W);
    plant_x[1] = clamp(longint'(s1), STATE_W);
    plant_x[2] = clamp(longint'(s2), STATE_W);
    drive_hold = 0;
  endfunction

  function automatic plant_out_t advance_plant();
    longint     k1 [3];
    longint     k2 [3];
    longint     k3 [3];
    longint     k4 [3];
    longint     xt [3];
    longint     dt;
    longint     inc;
    plant_out_t res;
    dt = longint'(dt_reg);
    for (int i = 0; i < 3; i++) k1[i] = slope_row(i, plant_x[0], plant_x[1], plant_x[2]);
    for (int i = 0; i < 3; i++) xt[i] = clamp(plant_x[i] + (qmul(k1[i], dt) >>> 1), STATE_W);
    for (int i = 0; i < 3; i++) k2[i] = slope_row(i, xt[0], xt[1], xt[2]);
    for (int i = 0; i < 3; i++) xt[i] = clamp(plant_x[i] + (qmul(k2[i], dt) >>> 1), STATE_W);
    for (int i = 0; i < 3; i++) k3[i] = slope_row(i, xt[0], xt[1], xt[2]);
    for (int i = 0; i < 3; i++) xt[i] = clamp(plant_x[i] + qmul(k3[i], dt), STATE_W);
    for (int i = 0; i < 3; i++) k4[i] = slope_row(i, xt[0], xt[1], xt[2]);
    for (int i = 0; i < 3; i++) begin
      inc = qmul(k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i], dt);
      // floor division by six
      inc = (inc < 0) ? (inc - 5) / 6 : inc / 6;
      plant_x[i] = clamp(plant_x[i] + inc, STATE_W);
    end
    res.y_meas  = IO_W'(clamp(dot_row(int'(REG_C_ROW)), IO_W));
    drive_hold  = clamp(-dot_row(int'(REG_K_GAIN)), IO_W);
    res.u_drive = IO_W'(drive_hold);
    res.x0      = IO_W'(clamp(plant_x[0], IO_W));
    res.x1      = IO_W'(clamp(plant_x[1], IO_W));
    res.x2      = IO_W'(clamp(plant_x[2], IO_W));
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack3(input int c0, input int c1, input int c2);
    return {COEF_W'(c2), COEF_W'(c1), COEF_W'(c0)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_coefs(input int span);
    int c [3];
    for (int i = 0; i < 3; i++) c[i] = int'($urandom_range(0, 2 * span - 1)) - span;
    return pack3(c[0], c[1], c[2]);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return CFG_DATA_W'({$urandom, $urandom});
  endfunction

  function automatic logic signed [IO_W-1:0] pick_state();
    int v;
    case ($urandom_range(0, 7))
      0: return Q16_MAX;
      1: return Q16_MIN;
      2, 3: return $urandom;
      default: begin
        v = int'($urandom_range(0, 4194303)) - 2097152;
        return v;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic signed [IO_W-1:0] want,
                                      input logic signed [IO_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result side stalls: calm stretches alternate with bursty stalls
  int stall_left = 0;
  int calm_left  = 0;
  bit calm       = 1'b0;

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      calm_left = $urandom_range(200, 2000);
    end
    calm_left--;
    if (calm || (stall_left == 0 && $urandom_range(0, 4) != 0)) begin
      res_if.ready <= 1'b1;
    end else begin
      if (stall_left == 0) stall_left = $urandom_range(1, 24);
      stall_left--;
      res_if.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    plant_out_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result beat with no step outstanding");
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        check_field("measured_output", want.y_meas, res_if.measured_output);
        check_field("drive_value", want.u_drive, res_if.drive_value);
        check_field("state_out_zero", want.x0, res_if.state_out_zero);
        check_field("state_out_one", want.x1, res_if.state_out_one);
        check_field("state_out_two", want.x2, res_if.state_out_two);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DT) dt_reg = data[DT_W-1:0];
    else if (idx != REG_SPARE) coef_reg[idx] = data;
  endtask

  task automatic program_plant(input logic [CFG_DATA_W-1:0] a0, input logic [CFG_DATA_W-1:0] a1,
                               input logic [CFG_DATA_W-1:0] a2, input logic [CFG_DATA_W-1:0] b,
                               input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] k,
                               input logic [DT_W-1:0] dt);
    write_reg(REG_A_ROW0, a0);
    write_reg(REG_A_ROW1, a1);
    write_reg(REG_A_ROW2, a2);
    write_reg(REG_B_COL, b);
    write_reg(REG_C_ROW, c);
    write_reg(REG_K_GAIN, k);
    write_reg(REG_DT, CFG_DATA_W'(dt));
  endtask

  // drain: all results back, then the core's own latency
  task automatic settle();
    cmd_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_beat(input logic fn, input logic signed [IO_W-1:0] s0,
                           input logic signed [IO_W-1:0] s1, input logic signed [IO_W-1:0] s2);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid           <= 1'b1;
    cmd_if.func            <= fn;
    cmd_if.load_state_zero <= s0;
    cmd_if.load_state_one  <= s1;
    cmd_if.load_state_two  <= s2;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    if (fn == FUNC_STEP) pending_outputs.push_back(advance_plant());
    else load_plant(s0, s1, s2);
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_beat(FUNC_STEP, $urandom, $urandom, $urandom);
  endtask

  task automatic test_reset_plant();
    send_steps(2);
    settle();
  endtask

  task automatic test_directed_dynamics();
    program_plant(pack3(0, COEF_ONE, 0), pack3(0, 0, COEF_ONE),
                  pack3(-COEF_ONE, -2 * COEF_ONE, -2 * COEF_ONE), pack3(0, 0, COEF_ONE),
                  pack3(COEF_ONE, 0, 0), pack3(COEF_ONE / 2, COEF_ONE / 4, 0), DT_RESET);
    send_beat(FUNC_LOAD, Q16_ONE, '0, '0);
    send_steps(3);
    send_beat(FUNC_LOAD, Q16_MAX, Q16_MIN, '0);
    send_steps(2);
    send_beat(FUNC_LOAD, -1, 1, -1);
    send_steps(1);
    settle();
  endtask

  task automatic test_zero_time_step();
    write_reg(REG_DT, '0);
    send_beat(FUNC_LOAD, 12345678, -2345678, 99999);
    send_steps(2);
    settle();
  endtask

  // big C and negative K push y and u past 32 bits; B feeds the clipped drive back
  task automatic test_output_saturation();
    program_plant('0, '0, '0, pack3(COEF_ONE, COEF_ONE, COEF_ONE),
                  pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MIN, COEF_MIN, COEF_MIN),
                  DT_RESET);
    send_beat(FUNC_LOAD, Q16_MAX, Q16_MAX, Q16_MAX);
    send_steps(2);
    send_beat(FUNC_LOAD, Q16_MIN, Q16_MIN, Q16_MIN);
    send_steps(1);
    settle();
  endtask

  task automatic test_register_index_ignored();
    write_reg(REG_SPARE, '1);
    send_steps(1);
    settle();
  endtask

  task automatic run_trajectories(input int count);
    int sent;
    int steps;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        7, 8: begin
          steps = $urandom_range(1, 8);
          send_steps(steps);
          sent += steps;
        end
        9: begin
          send_beat(1'($urandom), $urandom, $urandom, $urandom);
          sent++;
        end
        default: begin
          steps = $urandom_range(1, 15);
          send_beat(FUNC_LOAD, pick_state(), pick_state(), pick_state());
          send_steps(steps);
          sent += steps + 1;
        end
      endcase
    end
  endtask

  task automatic test_random_trajectories();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        1, 7: program_plant(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                            rand_word(), DT_W'($urandom_range(1, DT_MAX)));
        2: program_plant(pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MAX, COEF_MAX, COEF_MAX),
                         pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MAX, COEF_MAX, COEF_MAX),
                         pack3(COEF_MAX, COEF_MAX, COEF_MAX), pack3(COEF_MAX, COEF_MAX, COEF_MAX),
                         DT_MAX);
        3: program_plant(pack3(COEF_MIN, COEF_MIN, COEF_MIN), pack3(COEF_MIN, COEF_MIN, COEF_MIN),
                         pack3(COEF_MIN, COEF_MIN, COEF_MIN), pack3(COEF_MIN, COEF_MIN, COEF_MIN),
                         pack3(COEF_MIN, COEF_MIN, COEF_MIN), pack3(COEF_MIN, COEF_MIN, COEF_MIN),
                         DT_W'(1));
        4: program_plant(rand_coefs(COEF_ONE), rand_coefs(COEF_ONE), rand_coefs(COEF_ONE),
                         rand_coefs(COEF_ONE), rand_coefs(COEF_ONE), rand_coefs(COEF_ONE), '0);
        5: program_plant('1, '1, '1, '1, '1, '1, DT_W'($urandom_range(1, 4000)));
        8: program_plant(rand_coefs(COEF_MAX), rand_coefs(COEF_MAX), rand_coefs(COEF_MAX),
                         rand_coefs(COEF_MAX), rand_coefs(COEF_MAX), rand_coefs(COEF_MAX),
                         DT_RESET);
        default: program_plant(rand_coefs(2 * COEF_ONE), rand_coefs(2 * COEF_ONE),
                               rand_coefs(2 * COEF_ONE), rand_coefs(COEF_ONE),
                               rand_coefs(COEF_ONE), rand_coefs(COEF_ONE),
                               DT_W'($urandom_range(1, 2000)));
      endcase
      if ($urandom_range(0, 1) != 0) write_reg(REG_SPARE, rand_word());
      run_trajectories(155);
      settle();
    end
  endtask

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_data               = '0;
    cmd_if.valid           = 1'b0;
    cmd_if.func            = FUNC_LOAD;
    cmd_if.load_state_zero = '0;
    cmd_if.load_state_one  = '0;
    cmd_if.load_state_two  = '0;
    for (int i = 0; i < 3; i++) plant_x[i] = 0;
    for (int i = 0; i < 6; i++) coef_reg[i] = '0;
    drive_hold = 0;
    dt_reg     = DT_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_plant();
    test_directed_dynamics();
    test_zero_time_step();
    test_output_saturation();
    test_register_index_ignored();
    test_random_trajectories();
    settle();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
